@@ src/prt_pkg.sv @@
package prt_pkg;

  // Table geometry
  localparam int MaxAreas = 16;
  localparam int IdxW     = $clog2(MaxAreas);
  localparam int CntW     = $clog2(MaxAreas + 1);

  // Field widths fixed by the interface
  localparam int CoordW    = 16;
  localparam int AreaCntW  = 5;
  localparam int MarginW   = 8;
  localparam int SlotW     = 4;
  localparam int CmpW      = 18;
  localparam int ApbDataW  = 32;
  localparam int ApbAddrW  = 3;

  localparam logic [MarginW-1:0]  MarginReset = MarginW'(4);
  localparam logic [AreaCntW-1:0] CountReset  = '0;

  typedef struct packed {
    logic                     mode;
    logic [SlotW-1:0]         entry_index;
    logic signed [CoordW-1:0] rect_min_x;
    logic signed [CoordW-1:0] rect_min_y;
    logic signed [CoordW-1:0] rect_max_x;
    logic signed [CoordW-1:0] rect_max_y;
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
  } in_beat_t;

  typedef struct packed {
    logic             found;
    logic [SlotW-1:0] area_index;
  } out_beat_t;

  typedef struct packed {
    logic signed [CoordW-1:0] min_x;
    logic signed [CoordW-1:0] min_y;
    logic signed [CoordW-1:0] max_x;
    logic signed [CoordW-1:0] max_y;
  } rect_t;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StStay,
    StBase,
    StDone
  } state_e;

  typedef enum logic [1:0] {
    SelScan,
    SelProg,
    SelZero
  } sel_e;

  typedef enum logic {
    RegAreaCount = 1'b0,
    RegMargin    = 1'b1
  } reg_e;

  // Controller to datapath
  typedef struct packed {
    logic load;       // load beat accepted
    logic capture;    // query beat accepted
    logic idx_step;   // advance scan index
    sel_e sel;        // table read address source
    logic use_margin; // widen the checked rectangle
    logic res_set;    // latch result
    logic res_found;
    logic move_prog;  // progress takes the read address
    logic out_load;   // move result into output register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic hit;
    logic scan_live;
    logic prog_ok;
    logic cnt_zero;
  } dp_stat_t;

endpackage

@@ src/progressive_region_tracker.sv @@
// Load beat: taken in idle, no result; the next beat can follow in the next cycle.
// Query beat: the scan checks the entries after progress, one per cycle, below the saturated
// area count and stops at a hit; otherwise a stay check follows and, if it misses, a base
// check, then the output register is loaded; a zero count goes straight to that load.
// Input stalls until the result is loaded: a new query waits until the last one is done.
// Reset (rst_ni low, asynchronous): progress 0, area_count 0, margin 4, no result; table kept.
module progressive_region_tracker (
  input  logic                           clk_i,
  input  logic                           rst_ni,

  // Input channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  prt_pkg::in_beat_t              in_beat_i,

  // Result channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output prt_pkg::out_beat_t             out_beat_o,

  // Register port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [prt_pkg::ApbAddrW-1:0]   paddr,
  input  logic [prt_pkg::ApbDataW-1:0]   pwdata,
  output logic [prt_pkg::ApbDataW-1:0]   prdata,
  output logic                           pready
);

  // Registers sit at byte offsets 0 (area_count) and 4 (hysteresis_margin).
  // Only paddr[2] decodes the register; writes are expected only while idle.
  logic [prt_pkg::AreaCntW-1:0] area_count_q;
  logic [prt_pkg::MarginW-1:0]  margin_q;
  logic                         wr_en;
  prt_pkg::reg_e                reg_sel;

  prt_pkg::ctrl_cmd_t cmd;
  prt_pkg::dp_stat_t  stat;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = prt_pkg::reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      area_count_q <= prt_pkg::CountReset;
      margin_q     <= prt_pkg::MarginReset;
    end else if (wr_en) begin
      unique case (reg_sel)
        prt_pkg::RegAreaCount: area_count_q <= pwdata[prt_pkg::AreaCntW-1:0];
        prt_pkg::RegMargin:    margin_q     <= pwdata[prt_pkg::MarginW-1:0];
        default: ;
      endcase
    end
  end

  // Readback of the addressed register, zero-extended
  always_comb begin
    unique case (reg_sel)
      prt_pkg::RegAreaCount: prdata = prt_pkg::ApbDataW'(area_count_q);
      prt_pkg::RegMargin:    prdata = prt_pkg::ApbDataW'(margin_q);
      default:               prdata = '0;
    endcase
  end

  // Sequencer: idle takes beats, scan walks entries after progress,
  // stay checks the widened current area, base checks area 0, done
  // waits for the output register to free up.
  prt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_mode_i   (in_beat_i.mode),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Datapath: rectangle file, progress, query point, one containment check
  // per cycle at 18 bits, and the result and output registers.
  prt_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_beat_i    (in_beat_i),
    .area_count_i (area_count_q),
    .margin_i     (margin_q),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_beat_o   (out_beat_o)
  );

endmodule

@@ src/prt_dp.sv @@
module prt_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  prt_pkg::in_beat_t              in_beat_i,
  input  logic [prt_pkg::AreaCntW-1:0]   area_count_i,
  input  logic [prt_pkg::MarginW-1:0]    margin_i,
  input  prt_pkg::ctrl_cmd_t             cmd_i,
  output prt_pkg::dp_stat_t              stat_o,
  output prt_pkg::out_beat_t             out_beat_o
);

  prt_pkg::rect_t                   table_q [prt_pkg::MaxAreas];
  logic signed [prt_pkg::CoordW-1:0] x_q, y_q;
  logic [prt_pkg::IdxW-1:0]         prog_q;
  logic [prt_pkg::CntW-1:0]         idx_q;
  logic                             res_found_q;
  logic [prt_pkg::IdxW-1:0]         res_idx_q;
  prt_pkg::out_beat_t               out_q;

  logic [prt_pkg::CntW-1:0]         eff_cnt;
  logic                             slot_ok;
  logic [prt_pkg::IdxW-1:0]         rd_addr;
  prt_pkg::rect_t                   rd_rect;
  logic signed [prt_pkg::CmpW-1:0]  m_s, px, py, lo_x, lo_y, hi_x, hi_y;

  // Saturate the count to the table depth
  assign eff_cnt = (area_count_i > prt_pkg::AreaCntW'(prt_pkg::MaxAreas)) ?
                   prt_pkg::CntW'(prt_pkg::MaxAreas) : prt_pkg::CntW'(area_count_i);
  assign slot_ok = prt_pkg::CntW'(in_beat_i.entry_index) < prt_pkg::CntW'(prt_pkg::MaxAreas);

  always_comb begin
    unique case (cmd_i.sel)
      prt_pkg::SelScan: rd_addr = idx_q[prt_pkg::IdxW-1:0];
      prt_pkg::SelProg: rd_addr = prog_q;
      prt_pkg::SelZero: rd_addr = '0;
      default:          rd_addr = '0;
    endcase
  end

  assign rd_rect = table_q[rd_addr];

  // 18-bit signed compares cannot wrap
  assign m_s  = cmd_i.use_margin ? prt_pkg::CmpW'(margin_i) : '0;
  assign px   = prt_pkg::CmpW'(x_q);
  assign py   = prt_pkg::CmpW'(y_q);
  assign lo_x = prt_pkg::CmpW'(rd_rect.min_x) - m_s;
  assign lo_y = prt_pkg::CmpW'(rd_rect.min_y) - m_s;
  assign hi_x = prt_pkg::CmpW'(rd_rect.max_x) + m_s;
  assign hi_y = prt_pkg::CmpW'(rd_rect.max_y) + m_s;

  assign stat_o.hit       = (px >= lo_x) && (px < hi_x) && (py >= lo_y) && (py < hi_y);
  assign stat_o.scan_live = idx_q < eff_cnt;
  assign stat_o.prog_ok   = (prog_q != '0) && (prt_pkg::CntW'(prog_q) < eff_cnt);
  assign stat_o.cnt_zero  = (eff_cnt == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && slot_ok) begin
      table_q[in_beat_i.entry_index[prt_pkg::IdxW-1:0]] <= '{
        min_x: in_beat_i.rect_min_x, min_y: in_beat_i.rect_min_y,
        max_x: in_beat_i.rect_max_x, max_y: in_beat_i.rect_max_y};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prog_q <= '0;
    end else if (cmd_i.load && slot_ok) begin
      prog_q <= '0;
    end else if (cmd_i.move_prog) begin
      prog_q <= rd_addr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      x_q   <= in_beat_i.pos_x;
      y_q   <= in_beat_i.pos_y;
      idx_q <= prt_pkg::CntW'(prog_q) + prt_pkg::CntW'(1);
    end else if (cmd_i.idx_step) begin
      idx_q <= idx_q + prt_pkg::CntW'(1);
    end
    if (cmd_i.res_set) begin
      res_found_q <= cmd_i.res_found;
      res_idx_q   <= cmd_i.res_found ? rd_addr : '0;
    end
    if (cmd_i.out_load) begin
      out_q.found      <= res_found_q;
      out_q.area_index <= prt_pkg::SlotW'(res_idx_q);
    end
  end

  assign out_beat_o = out_q;

endmodule

@@ src/prt_ctrl.sv @@
module prt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_mode_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  prt_pkg::dp_stat_t  stat_i,
  output prt_pkg::ctrl_cmd_t cmd_o
);

  prt_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      prt_pkg::StIdle: begin
        if (in_valid_i && !in_mode_i) begin
          state_d = stat_i.cnt_zero ? prt_pkg::StDone : prt_pkg::StScan;
        end
      end
      prt_pkg::StScan: begin
        if (!stat_i.scan_live) begin
          state_d = prt_pkg::StStay;
        end else if (stat_i.hit) begin
          state_d = prt_pkg::StDone;
        end
      end
      prt_pkg::StStay: begin
        state_d = (stat_i.prog_ok && stat_i.hit) ? prt_pkg::StDone : prt_pkg::StBase;
      end
      prt_pkg::StBase: state_d = prt_pkg::StDone;
      prt_pkg::StDone: begin
        if (out_free) begin
          state_d = prt_pkg::StIdle;
        end
      end
      default: state_d = prt_pkg::StIdle;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.sel  = prt_pkg::SelScan;
    in_stall_o = 1'b1;
    unique case (state_q)
      prt_pkg::StIdle: begin
        in_stall_o    = 1'b0;
        cmd_o.load    = in_valid_i && in_mode_i;
        cmd_o.capture = in_valid_i && !in_mode_i;
        cmd_o.res_set = in_valid_i && !in_mode_i && stat_i.cnt_zero;
      end
      prt_pkg::StScan: begin
        cmd_o.sel       = prt_pkg::SelScan;
        cmd_o.res_set   = stat_i.scan_live && stat_i.hit;
        cmd_o.res_found = 1'b1;
        cmd_o.move_prog = stat_i.scan_live && stat_i.hit;
        cmd_o.idx_step  = stat_i.scan_live && !stat_i.hit;
      end
      prt_pkg::StStay: begin
        cmd_o.sel        = prt_pkg::SelProg;
        cmd_o.use_margin = 1'b1;
        cmd_o.res_set    = stat_i.prog_ok && stat_i.hit;
        cmd_o.res_found  = 1'b1;
      end
      prt_pkg::StBase: begin
        cmd_o.sel       = prt_pkg::SelZero;
        cmd_o.res_set   = 1'b1;
        cmd_o.res_found = stat_i.hit;
        cmd_o.move_prog = stat_i.hit;
      end
      prt_pkg::StDone: begin
        cmd_o.out_load = out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= prt_pkg::StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
